// ===== sv/tbp_pkg.sv =====
package tbp_pkg;

	// default table sizes, as history or index widths
	localparam int unsigned MAX_GLOBAL_BITS_DEF = 12;
	localparam int unsigned MAX_LOCAL_BITS_DEF  = 12;
	localparam int unsigned MAX_PC_BITS_DEF     = 12;

	// configuration register indexes
	localparam logic [1:0] CFG_GLOBAL_BITS = 2'd0;
	localparam logic [1:0] CFG_LOCAL_BITS  = 2'd1;
	localparam logic [1:0] CFG_PC_BITS     = 2'd2;

	// configuration reset values
	localparam logic [3:0] GLOBAL_BITS_RST = 4'd9;
	localparam logic [3:0] LOCAL_BITS_RST  = 4'd10;
	localparam logic [3:0] PC_BITS_RST     = 4'd10;

	// counter reset values
	localparam logic [1:0] CTR_RST     = 2'd1;
	localparam logic [1:0] CHOOSER_RST = 2'd2;

	// item kinds on tuser
	localparam logic MODE_PREDICT = 1'b0;
	localparam logic MODE_TRAIN   = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_RESOLVE
	} tbp_state_t;

	typedef struct packed {
		logic [1:0] chooser;
		logic [1:0] gctr;
		logic [1:0] lctr;
	} tbp_ctrs_t;

	// effective width: zero acts as one, clipped at the table maximum
	function automatic logic [4:0] clamp_width(input logic [3:0] v, input int unsigned max_bits);
		logic [4:0] w;
		w = (v == 4'd0) ? 5'd1 : {1'b0, v};
		if (w > 5'(max_bits))
			w = 5'(max_bits);
		return w;
	endfunction

	function automatic logic [1:0] sat_step(input logic [1:0] c, input logic up);
		logic [1:0] r;
		if (up)
			r = (c == 2'd3) ? 2'd3 : c + 2'd1;
		else
			r = (c == 2'd0) ? 2'd0 : c - 2'd1;
		return r;
	endfunction

endpackage

// ===== sv/tournament_branch_predictor_top.sv =====
// Tournament branch predictor. A word on the input carries a kind in in_tuser
// (predict or train) and the branch address and resolved outcome in in_tdata.
// A predict word returns one word holding the predicted direction; a train word
// returns nothing and updates the chooser, both 2-bit counters and both
// histories. Items are handled one at a time in three steps: accept and read
// the local history and the global/chooser entry, read the local counter
// addressed by that history, then resolve and write back. The two dependent
// reads of single-port synchronous tables set these steps. A predict result
// that finds the output register still full waits in the resolve step until
// the word ahead has been taken. After reset the block sweeps all tables to
// their reset values, one entry a cycle, over all 2**max(MAX_GLOBAL_BITS,
// MAX_LOCAL_BITS, MAX_PC_BITS) addresses (4096 at the defaults); in_tready
// stays low meanwhile, configuration writes are taken as ever. Width
// registers may be written only while the block is idle.
module tournament_branch_predictor_top
	import tbp_pkg::*;
#(
	parameter int unsigned MAX_GLOBAL_BITS = MAX_GLOBAL_BITS_DEF,
	parameter int unsigned MAX_LOCAL_BITS  = MAX_LOCAL_BITS_DEF,
	parameter int unsigned MAX_PC_BITS     = MAX_PC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_wdata,

	// input words
	input  logic        in_tvalid,
	output logic        in_tready,
	input  logic [39:0] in_tdata,   // [31:0] pc, [32] taken, [39:33] zero
	input  logic        in_tuser,   // [0] mode

	// result words
	output logic        out_tvalid,
	input  logic        out_tready,
	output logic [7:0]  out_tdata   // [0] prediction, [7:1] zero
);

	localparam int unsigned G = MAX_GLOBAL_BITS;
	localparam int unsigned L = MAX_LOCAL_BITS;
	localparam int unsigned P = MAX_PC_BITS;
	localparam int unsigned GL_MAX = (G > L) ? G : L;
	localparam int unsigned CLR_W  = (GL_MAX > P) ? GL_MAX : P;
	localparam int unsigned GDEPTH = 1 << G;
	localparam int unsigned LDEPTH = 1 << L;
	localparam int unsigned PDEPTH = 1 << P;

	// configuration
	logic [3:0] gbits_q;
	logic [3:0] lbits_q;
	logic [3:0] pbits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gbits_q <= GLOBAL_BITS_RST;
			lbits_q <= LOCAL_BITS_RST;
			pbits_q <= PC_BITS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GLOBAL_BITS: gbits_q <= cfg_wdata;
				CFG_LOCAL_BITS:  lbits_q <= cfg_wdata;
				CFG_PC_BITS:     pbits_q <= cfg_wdata;
				default: ;  // unknown index, write dropped
			endcase
		end
	end

	// history masks from the clamped widths
	logic [4:0]   gw;
	logic [4:0]   lw;
	logic [4:0]   pw;
	logic [G-1:0] gmask;
	logic [L-1:0] lmask;
	logic [P-1:0] pmask;

	assign gw = clamp_width(gbits_q, G);
	assign lw = clamp_width(lbits_q, L);
	assign pw = clamp_width(pbits_q, P);

	always_comb begin
		for (int i = 0; i < G; i++)
			gmask[i] = (5'(i) < gw);
		for (int i = 0; i < L; i++)
			lmask[i] = (5'(i) < lw);
		for (int i = 0; i < P; i++)
			pmask[i] = (5'(i) < pw);
	end

	// sequencer
	tbp_state_t state_q;
	tbp_state_t state_d;
	logic [CLR_W-1:0] clr_q;
	logic out_valid_q;
	logic pred_q;
	logic mode_s1;
	logic taken_s1;
	logic out_free;
	logic in_acc;
	logic clearing;
	logic lookup;
	logic train_wr;
	logic pred_wr;

	assign clearing = (state_q == ST_CLEAR);
	assign lookup   = (state_q == ST_LOOKUP);
	assign out_free = !out_valid_q || out_tready;
	assign in_acc   = in_tvalid && in_tready;
	assign train_wr = (state_q == ST_RESOLVE) && (mode_s1 == MODE_TRAIN);
	assign pred_wr  = (state_q == ST_RESOLVE) && (mode_s1 == MODE_PREDICT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		in_tready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == {CLR_W{1'b1}})
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_tready = 1'b1;
				if (in_tvalid)
					state_d = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				state_d = ST_RESOLVE;
			end
			ST_RESOLVE: begin
				// a predict waits here while the output register is still full
				if (train_wr || pred_wr)
					state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// clearing sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_q <= '0;
		else if (clearing)
			clr_q <= clr_q + 1'b1;
	end

	// stage 1: item fields and table addresses
	logic [G-1:0] ghist_q;
	logic [G-1:0] gidx_in;
	logic [P-1:0] pidx_in;
	logic [G-1:0] gidx_s1;
	logic [P-1:0] pidx_s1;

	assign gidx_in = ghist_q & gmask;
	assign pidx_in = in_tdata[P-1:0] & pmask;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_s1  <= in_tuser;
			taken_s1 <= in_tdata[32];
			gidx_s1  <= gidx_in;
			pidx_s1  <= pidx_in;
		end
	end

	// global/chooser table: {chooser, global counter}
	logic [3:0]   gm_mem [GDEPTH];
	logic [3:0]   gm_rd_s1;
	logic         gm_we;
	logic [G-1:0] gm_waddr;
	logic [3:0]   gm_wdata;

	// local history table
	logic [L-1:0] lh_mem [PDEPTH];
	logic [L-1:0] lh_rd_s1;
	logic         lh_we;
	logic [P-1:0] lh_waddr;
	logic [L-1:0] lh_wdata;

	// local counter table
	logic [1:0]   lc_mem [LDEPTH];
	logic [1:0]   lc_rd_s2;
	logic         lc_we;
	logic [L-1:0] lc_waddr;
	logic [1:0]   lc_wdata;

	// stage 2: local history masked into the local counter index
	logic [L-1:0] lidx;
	logic [L-1:0] lidx_s2;

	assign lidx = lh_rd_s1 & lmask;

	always_ff @(posedge clk) begin
		if (lookup)
			lidx_s2 <= lidx;
	end

	// resolve: counter update and new histories
	tbp_ctrs_t ctrs;
	tbp_ctrs_t ctrs_new;
	logic      prediction;
	logic [L:0] lh_shift;
	logic [G:0] gh_shift;

	assign ctrs.chooser = gm_rd_s1[3:2];
	assign ctrs.gctr    = gm_rd_s1[1:0];
	assign ctrs.lctr    = lc_rd_s2;

	tbp_counter_update u_upd (
		.ctrs       (ctrs),
		.taken      (taken_s1),
		.ctrs_new   (ctrs_new),
		.prediction (prediction)
	);

	assign lh_shift = {lidx_s2, taken_s1};
	assign gh_shift = {gidx_s1, taken_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ghist_q <= '0;
		else if (train_wr)
			ghist_q <= gh_shift[G-1:0] & gmask;
	end

	// write ports, shared between the clearing sweep and training
	assign gm_we    = clearing || train_wr;
	assign gm_waddr = clearing ? clr_q[G-1:0] : gidx_s1;
	assign gm_wdata = clearing ? {CHOOSER_RST, CTR_RST} : {ctrs_new.chooser, ctrs_new.gctr};

	assign lh_we    = clearing || train_wr;
	assign lh_waddr = clearing ? clr_q[P-1:0] : pidx_s1;
	assign lh_wdata = clearing ? '0 : (lh_shift[L-1:0] & lmask);

	assign lc_we    = clearing || train_wr;
	assign lc_waddr = clearing ? clr_q[L-1:0] : lidx_s2;
	assign lc_wdata = clearing ? CTR_RST : ctrs_new.lctr;

	always_ff @(posedge clk) begin
		if (gm_we)
			gm_mem[gm_waddr] <= gm_wdata;
		if (in_acc)
			gm_rd_s1 <= gm_mem[gidx_in];
	end

	always_ff @(posedge clk) begin
		if (lh_we)
			lh_mem[lh_waddr] <= lh_wdata;
		if (in_acc)
			lh_rd_s1 <= lh_mem[pidx_in];
	end

	always_ff @(posedge clk) begin
		if (lc_we)
			lc_mem[lc_waddr] <= lc_wdata;
		if (lookup)
			lc_rd_s2 <= lc_mem[lidx];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (pred_wr)
			out_valid_q <= 1'b1;
		else if (out_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pred_wr)
			pred_q <= prediction;
	end

	assign out_tvalid = out_valid_q;
	assign out_tdata  = {7'd0, pred_q};

`ifndef SYNTHESIS
	// an accepted word always moves on to the local counter read
	a_accept_to_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == ST_LOOKUP)
		else $error("accepted word did not enter lookup");

	// a result only appears out of the resolve step of a predict word
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_tvalid) |-> $past(state_q == ST_RESOLVE && mode_s1 == MODE_PREDICT))
		else $error("result word without a predict item");

	// the global history never holds bits beyond its configured width
	a_ghist_masked: assert property (@(posedge clk) disable iff (!arst_n)
		train_wr |=> (ghist_q & ~$past(gmask)) == '0)
		else $error("global history exceeds its width");

	// no table write while a word is being looked up
	a_no_write_in_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		lookup |-> !(gm_we || lh_we || lc_we))
		else $error("table written during lookup");
`endif

endmodule

// ===== sv/tbp_counter_update.sv =====
module tbp_counter_update
	import tbp_pkg::*;
(
	input  tbp_ctrs_t ctrs,
	input  logic      taken,
	output tbp_ctrs_t ctrs_new,
	output logic      prediction
);

	logic lpred;
	logic gpred;

	assign lpred = ctrs.lctr[1];
	assign gpred = ctrs.gctr[1];

	// upper chooser bit picks the global component
	assign prediction = ctrs.chooser[1] ? gpred : lpred;

	always_comb begin
		ctrs_new = ctrs;
		// chooser moves only when exactly one component was right
		if (lpred == taken && gpred != taken)
			ctrs_new.chooser = sat_step(ctrs.chooser, 1'b0);
		else if (gpred == taken && lpred != taken)
			ctrs_new.chooser = sat_step(ctrs.chooser, 1'b1);
		ctrs_new.lctr = sat_step(ctrs.lctr, taken);
		ctrs_new.gctr = sat_step(ctrs.gctr, taken);
	end

endmodule

// ===== bench/tournament_branch_predictor_top_tb.sv =====
module tournament_branch_predictor_top_tb;
	import tbp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// index with no register behind it
	localparam logic [1:0] CFG_SPARE_IDX = 2'd3;

	// one input word as the sender sees it
	typedef struct {
		logic        mode;
		logic [31:0] pc;
		logic        taken;
	} branch_word_t;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        cfg_we     = 1'b0;
	logic [1:0]  cfg_index  = CFG_GLOBAL_BITS;
	logic [3:0]  cfg_wdata  = 4'd0;
	logic        in_tvalid  = 1'b0;
	logic        in_tready;
	logic [39:0] in_tdata   = '0;   // [31:0] pc, [32] taken, [39:33] zero
	logic        in_tuser   = MODE_PREDICT;   // [0] mode
	logic        out_tvalid;
	logic        out_tready = 1'b0;
	logic [7:0]  out_tdata;  // [0] prediction, [7:1] zero

	// words waiting to be offered, and directions still owed by the block
	branch_word_t branch_words[$];
	logic         owed_directions[$];

	// shadow of the width registers and of every table
	logic [3:0]  ghist_bits_reg;
	logic [3:0]  lhist_bits_reg;
	logic [3:0]  pc_bits_reg;
	logic [11:0] global_hist;
	logic [11:0] local_hist [4096];
	logic [1:0]  local_ctr  [4096];
	logic [1:0]  global_ctr [4096];
	logic [1:0]  choice_ctr [4096];

	int unsigned cyc = 0;
	int          send_gap = 0;
	int          stall_left = 0;
	int          results_seen = 0;
	int          long_hold_at = 60;
	int          errors = 0;

	tournament_branch_predictor_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_tvalid (in_tvalid),
		.in_tready (in_tready),
		.in_tdata  (in_tdata),
		.in_tuser  (in_tuser),
		.out_tvalid(out_tvalid),
		.out_tready(out_tready),
		.out_tdata (out_tdata)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cyc <= cyc + 1;
	end

	// effective width as a mask: zero behaves as one bit, anything past twelve as twelve
	function automatic logic [11:0] width_to_mask(input logic [3:0] bits);
		int b;
		b = (bits == 4'd0) ? 1 : ((bits > 4'd12) ? 12 : int'(bits));
		return 12'((1 << b) - 1);
	endfunction

	function automatic logic [1:0] saturate_toward(input logic [1:0] c, input logic up);
		if (up)
			return (c == 2'd3) ? 2'd3 : c + 2'd1;
		return (c == 2'd0) ? 2'd0 : c - 2'd1;
	endfunction

	// advance the shadow tables by one accepted word; a predict word owes one direction
	function automatic void tournament_step(input branch_word_t w);
		logic [11:0] gm, lm, pm, gidx, pidx, lidx;
		logic        lp, gp;
		gm   = width_to_mask(ghist_bits_reg);
		lm   = width_to_mask(lhist_bits_reg);
		pm   = width_to_mask(pc_bits_reg);
		gidx = global_hist & gm;
		pidx = w.pc[11:0] & pm;
		lidx = local_hist[pidx] & lm;
		lp   = local_ctr[lidx][1];
		gp   = global_ctr[gidx][1];
		if (w.mode == MODE_PREDICT) begin
			owed_directions.push_back(choice_ctr[gidx][1] ? gp : lp);
			return;
		end
		// chooser only moves when exactly one side was right
		if (lp == w.taken && gp != w.taken)
			choice_ctr[gidx] = saturate_toward(choice_ctr[gidx], 1'b0);
		else if (gp == w.taken && lp != w.taken)
			choice_ctr[gidx] = saturate_toward(choice_ctr[gidx], 1'b1);
		local_ctr[lidx]  = saturate_toward(local_ctr[lidx], w.taken);
		global_ctr[gidx] = saturate_toward(global_ctr[gidx], w.taken);
		local_hist[pidx] = {lidx[10:0], w.taken} & lm;
		global_hist      = {gidx[10:0], w.taken} & gm;
	endfunction

	// idle length: mostly none or short, now and then long; quiet stretches have none
	function automatic int draw_gap();
		int r;
		if ((cyc / 400) % 5 == 2)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// sender: offers the head of the queue, holds it until taken
	always @(posedge clk) begin
		logic offer;
		if (!arst_n) begin
			in_tvalid <= 1'b0;
			send_gap = 0;
		end else begin
			offer = in_tvalid;
			if (in_tvalid && in_tready) begin
				tournament_step(branch_words.pop_front());
				send_gap = draw_gap();
				offer = 1'b0;
			end
			if (!offer) begin
				if (send_gap > 0) begin
					send_gap--;
					in_tvalid <= 1'b0;
				end else if (branch_words.size() != 0) begin
					in_tvalid <= 1'b1;
					in_tdata  <= {7'd0, branch_words[0].taken, branch_words[0].pc};
					in_tuser  <= branch_words[0].mode;
				end else begin
					in_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks each result word, stalls at random and now and then for a long spell
	always @(posedge clk) begin
		logic exp_dir;
		if (!arst_n) begin
			out_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_tvalid && out_tready) begin
				if (owed_directions.size() == 0) begin
					$display("%0t: result word with none owed, expected none actual %h",
						$time, out_tdata);
					errors++;
				end else begin
					exp_dir = owed_directions.pop_front();
					if (out_tdata !== {7'd0, exp_dir}) begin
						$display("%0t: prediction mismatch, expected %h actual %h",
							$time, {7'd0, exp_dir}, out_tdata);
						errors++;
					end
				end
				results_seen++;
			end
			// long hold-off so that the block fills and pushes back on the sender
			if (results_seen >= long_hold_at) begin
				stall_left = 80;
				long_hold_at += 350;
			end else if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
				stall_left = draw_gap();
			end
			if (stall_left > 0) begin
				stall_left--;
				out_tready <= 1'b0;
			end else begin
				out_tready <= 1'b1;
			end
		end
	end

	task automatic queue_word(input logic mode, input logic [31:0] pc, input logic taken);
		branch_word_t w;
		w.mode  = mode;
		w.pc    = pc;
		w.taken = taken;
		branch_words.push_back(w);
	endtask

	// block idle: nothing queued, nothing owed, and time for a trailing train word
	task automatic wait_idle();
		while (branch_words.size() != 0 || owed_directions.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_GLOBAL_BITS: ghist_bits_reg = val;
			CFG_LOCAL_BITS:  lhist_bits_reg = val;
			CFG_PC_BITS:     pc_bits_reg    = val;
			default: ;   // unknown index leaves every width alone
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_widths(input logic [3:0] g, input logic [3:0] l, input logic [3:0] p);
		wait_idle();
		write_reg(CFG_GLOBAL_BITS, g);
		write_reg(CFG_LOCAL_BITS, l);
		write_reg(CFG_PC_BITS, p);
	endtask

	// branch trace: a handful of branches, each looping with its own trip count,
	// predicted and then trained; one draw in five is a single unrelated noise word
	task automatic queue_branch_trace(input int n_words);
		logic [31:0] pool [8];
		int          period [8];
		int          iter [8];
		int          k, made;
		logic        outcome;
		for (k = 0; k < 8; k++) begin
			pool[k]   = $urandom;
			period[k] = $urandom_range(1, 6);
			iter[k]   = 0;
		end
		made = 0;
		while (made < n_words) begin
			if ($urandom_range(0, 9) < 8) begin
				k = $urandom_range(0, 7);
				if (period[k] == 1)
					outcome = 1'($urandom_range(0, 1));
				else
					outcome = (iter[k] % period[k]) != (period[k] - 1);
				iter[k]++;
				queue_word(MODE_PREDICT, pool[k], 1'($urandom_range(0, 1)));
				queue_word(MODE_TRAIN, pool[k], outcome);
				made += 2;
			end else begin
				queue_word($urandom_range(0, 1) ? MODE_TRAIN : MODE_PREDICT, $urandom,
					1'($urandom_range(0, 1)));
				made++;
			end
		end
	endtask

	initial begin
		int i;
		ghist_bits_reg = GLOBAL_BITS_RST;
		lhist_bits_reg = LOCAL_BITS_RST;
		pc_bits_reg    = PC_BITS_RST;
		global_hist    = '0;
		for (i = 0; i < 4096; i++) begin
			local_hist[i] = '0;
			local_ctr[i]  = CTR_RST;
			global_ctr[i] = CTR_RST;
			choice_ctr[i] = CHOOSER_RST;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset widths, address extremes, aliasing on the low pc bits,
		// counters driven to both rails, taken bit set on predict words
		queue_word(MODE_PREDICT, 32'h0000_0000, 1'b1);
		queue_word(MODE_PREDICT, 32'hFFFF_FFFF, 1'b0);
		queue_word(MODE_TRAIN,   32'h0000_0000, 1'b1);
		queue_word(MODE_TRAIN,   32'h0000_0000, 1'b1);
		queue_word(MODE_PREDICT, 32'h0000_0000, 1'b0);
		queue_word(MODE_TRAIN,   32'hFFFF_FFFF, 1'b0);
		queue_word(MODE_TRAIN,   32'hFFFF_FFFF, 1'b0);
		queue_word(MODE_PREDICT, 32'hFFFF_FFFF, 1'b1);
		queue_word(MODE_TRAIN,   32'h8000_0000, 1'b1);
		queue_word(MODE_PREDICT, 32'h0000_0000, 1'b0);
		queue_word(MODE_TRAIN,   32'h0000_0000, 1'b0);
		queue_word(MODE_TRAIN,   32'h0000_0000, 1'b0);
		queue_word(MODE_TRAIN,   32'h0000_0000, 1'b0);
		queue_word(MODE_PREDICT, 32'h0000_0000, 1'b1);
		queue_word(MODE_TRAIN,   32'h7FFF_FC00, 1'b1);
		queue_word(MODE_PREDICT, 32'h0000_0000, 1'b0);
		queue_word(MODE_PREDICT, 32'h7FFF_FC00, 1'b0);

		queue_branch_trace(250);

		// narrowest widths
		set_widths(4'd1, 4'd1, 4'd1);
		queue_word(MODE_TRAIN,   32'h0000_0001, 1'b1);
		queue_word(MODE_PREDICT, 32'h0000_0001, 1'b0);
		queue_word(MODE_PREDICT, 32'hFFFF_FFFE, 1'b1);
		queue_branch_trace(150);

		// widest widths
		set_widths(4'd12, 4'd12, 4'd12);
		queue_branch_trace(300);

		// zero behaves as one; a write to the unused index changes nothing
		set_widths(4'd0, 4'd0, 4'd0);
		write_reg(CFG_SPARE_IDX, 4'd5);
		queue_branch_trace(150);

		// past the maximum behaves as the maximum
		set_widths(4'd15, 4'd13, 4'd14);
		queue_branch_trace(250);

		for (i = 0; i < 4; i++) begin
			set_widths(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
				4'($urandom_range(0, 15)));
			queue_branch_trace(200);
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("tournament_branch_predictor_top regression: pass");
		else
			$display("tournament_branch_predictor_top regression: fail");
		$finish;
	end

	// watchdog well past the slowest legal run, clearing sweep included
	initial begin
		#10_000_000;
		$display("tournament_branch_predictor_top regression: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/tbp_pkg.sv
sv/tbp_counter_update.sv
sv/tournament_branch_predictor_top.sv
bench/tournament_branch_predictor_top_tb.sv
